FILE: rtl/spc_pkg.sv
// shared constants, control types and state encoding of the stack permutation checker
package spc_pkg;

  localparam int CAR_W        = 11;
  localparam int LEN_W        = 11;
  localparam int NEXT_W       = LEN_W + 1;
  localparam int MAX_CARS_DEF = 1024;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_REFILL
  } spc_state_e;

  typedef struct packed {
    logic use_input;
    logic latch;
    logic push;
    logic check;
    logic refill;
  } spc_cmd_t;

  typedef struct packed {
    logic need_push;
    logic out_free;
    logic will_refill;
  } spc_status_t;

endpackage

FILE: rtl/spc_if.sv
// request channels for car numbers and for order results
interface spc_car_if
  import spc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CAR_W-1:0] car_number;

  modport source (output valid, output car_number, input ready);
  modport sink   (input valid, input car_number, output ready);
endinterface

interface spc_result_if;
  logic valid;
  logic ready;
  logic feasible;

  modport source (output valid, output feasible, input ready);
  modport sink   (input valid, input feasible, output ready);
endinterface

FILE: rtl/spc_ctrl.sv
// sequencer that steps pushes, the top-of-stack check and the top refill
module spc_ctrl
  import spc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  spc_status_t status_i,
  output spc_cmd_t    cmd_o
);

  spc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    cmd_o.use_input = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          if (status_i.need_push) begin
            cmd_o.push  = 1'b1;
            cmd_o.latch = 1'b1;
          end else begin
            cmd_o.check = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        if (status_i.need_push) begin
          cmd_o.push = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.check = 1'b1;
        end
      end
      ST_REFILL: begin
        cmd_o.refill = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free) begin
          if (status_i.need_push) begin
            state_d = ST_PUSH;
          end else if (status_i.will_refill) begin
            state_d = ST_REFILL;
          end
        end
      end
      ST_PUSH: begin
        if (!status_i.need_push && status_i.out_free) begin
          state_d = status_i.will_refill ? ST_REFILL : ST_IDLE;
        end
      end
      ST_REFILL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/spc_datapath.sv
// siding memory, counters, top-of-stack register and result register
module spc_datapath
  import spc_pkg::*;
#(
  parameter int MAX_CARS = MAX_CARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic [CAR_W-1:0] car_number_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             feasible_o,
  input  spc_cmd_t         cmd_i,
  output spc_status_t      status_o
);

  localparam int ADDR_W  = $clog2(MAX_CARS);
  localparam int DEPTH_W = $clog2(MAX_CARS + 1);

  logic [CAR_W-1:0]   mem [MAX_CARS];
  logic [CAR_W-1:0]   rdata_q;
  logic [LEN_W-1:0]   len_q;
  logic [LEN_W-1:0]   eff_len;
  logic [CAR_W-1:0]   car_q;
  logic [CAR_W-1:0]   car_sel;
  logic [CAR_W-1:0]   top_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [NEXT_W-1:0]  next_q;
  logic [LEN_W-1:0]   items_q;
  logic               failed_q;
  logic               out_valid_q;
  logic               feasible_q;
  logic               match;
  logic               finish;
  logic [ADDR_W-1:0]  rd_addr;

  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(len_q) > MAX_CARS) begin
      eff_len = LEN_W'(MAX_CARS);
    end else begin
      eff_len = len_q;
    end
  end

  assign car_sel = cmd_i.use_input ? car_number_i : car_q;
  assign match   = (depth_q != '0) && (top_q == car_sel);
  assign finish  = (({1'b0, items_q} + NEXT_W'(1)) >= {1'b0, eff_len});
  assign rd_addr = ADDR_W'(depth_q - DEPTH_W'(2));

  assign status_o.need_push   = !failed_q && (next_q <= {1'b0, car_sel}) &&
                                (next_q <= {1'b0, eff_len}) && (32'(depth_q) < MAX_CARS);
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.will_refill = !failed_q && match && (depth_q >= DEPTH_W'(2)) && !finish;

  assign out_valid_o = out_valid_q;
  assign feasible_o  = feasible_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[depth_q[ADDR_W-1:0]] <= next_q[CAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      car_q <= car_number_i;
    end
    if (cmd_i.push) begin
      top_q <= next_q[CAR_W-1:0];
    end else if (cmd_i.refill) begin
      top_q <= rdata_q;
    end
    if (cmd_i.check) begin
      feasible_q <= !failed_q && match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_RESET;
      depth_q     <= '0;
      next_q      <= NEXT_W'(1);
      items_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (cmd_i.check && finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        depth_q <= depth_q + DEPTH_W'(1);
        next_q  <= next_q + NEXT_W'(1);
      end else if (cmd_i.check) begin
        if (finish) begin
          depth_q  <= '0;
          next_q   <= NEXT_W'(1);
          items_q  <= '0;
          failed_q <= 1'b0;
        end else begin
          items_q <= items_q + LEN_W'(1);
          if (!failed_q) begin
            if (match) begin
              depth_q <= depth_q - DEPTH_W'(1);
            end else begin
              failed_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  a_push_check_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.check))
    else $error("push and check in the same cycle");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (32'(depth_q) < MAX_CARS))
    else $error("push beyond siding depth");

  a_check_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check |-> (!out_valid_q || out_ready_i))
    else $error("check while result slot is occupied");

  a_refill_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.refill |-> ($past(cmd_i.check) && $past(depth_q) >= DEPTH_W'(2)))
    else $error("refill without a preceding pop");

endmodule

FILE: rtl/stack_permutation_check.sv
// top level of the stack permutation checker
//
//   channel   dir  payload           meaning
//   car_i     in   car_number[10:0]  next car of the wanted order
//   result_o  out  feasible          order reachable through the siding
//   cfg       in   cfg_wdata_i[10:0] train length, written when cfg_we_i is high
//
// an item pushes the cars that it needs, then checks the top of the stack, and
// takes a further refill step when a pop leaves one or more cars on the siding and the
// order goes on; the single write port of the siding memory sets one push per cycle
// reset clears counters and flags at once; the siding memory is not cleared
// a result that waits for its ready blocks every new request and every check
module stack_permutation_check
  import spc_pkg::*;
#(
  parameter int MAX_CARS = MAX_CARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  spc_car_if.sink          car_i,
  spc_result_if.source     result_o
);

  spc_cmd_t    cmd;
  spc_status_t status;

  spc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (car_i.valid),
    .in_ready_o (car_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spc_datapath #(
    .MAX_CARS (MAX_CARS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .car_number_i (car_i.car_number),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .feasible_o   (result_o.feasible),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule
